FILE: design/rtfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtfb_pkg: shared types and constants for the transmit frame builder
// Request and result words, the internal frame record, frame byte codes
// and the escape test.
// ----------------------------------------------------------------------------
package rtfb_pkg;

	localparam logic [7:0] START_DELIM = 8'h7E;
	localparam logic [7:0] ESC_BYTE    = 8'h7D;
	localparam logic [7:0] XON_BYTE    = 8'h11;
	localparam logic [7:0] XOFF_BYTE   = 8'h13;
	localparam logic [7:0] ESC_XOR     = 8'h20;
	localparam logic [7:0] CKS_BASE    = 8'hFF;
	localparam logic [7:0] LEN_HIGH    = 8'h00;
	localparam logic [7:0] LEN_LOW     = 8'h07;
	localparam logic [7:0] FRAME_TYPE  = 8'h01;
	localparam logic [7:0] FRAME_ID    = 8'h00;
	localparam logic [7:0] OPT_RESET   = 8'h01;

	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	localparam int OB_DEPTH = 2;
	localparam int OB_PTR_W = (OB_DEPTH > 1) ? $clog2(OB_DEPTH) : 1;
	localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

	typedef struct packed {
		logic [7:0] dest_addr_high;
		logic [7:0] dest_addr_low;
		logic [7:0] data_first;
		logic [7:0] data_second;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} rsp_t;

	// Variable part of one frame, checksum already folded in.
	typedef struct packed {
		logic [7:0] addr_high;
		logic [7:0] addr_low;
		logic [7:0] options;
		logic [7:0] data_first;
		logic [7:0] data_second;
		logic [7:0] checksum;
	} frame_t;

	// Position of the unescaped byte being sent within the frame.
	typedef enum logic [3:0] {
		POS_DELIM,
		POS_LEN_HIGH,
		POS_LEN_LOW,
		POS_TYPE,
		POS_ID,
		POS_ADDR_HIGH,
		POS_ADDR_LOW,
		POS_OPTIONS,
		POS_DATA_FIRST,
		POS_DATA_SECOND,
		POS_CHECKSUM
	} pos_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == START_DELIM) || (b == ESC_BYTE) || (b == XON_BYTE) || (b == XOFF_BYTE);
	endfunction

endpackage
`default_nettype wire

FILE: design/rtfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtfb_front: request intake
// Holds the options register, accepts requests and turns each one into a
// frame record with its checksum for the frame queue.
// ----------------------------------------------------------------------------
module rtfb_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rtfb_pkg::req_t  req,
	output logic                 full,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [7:0]      cfg_data,
	input  wire logic            fq_full,
	output logic                 fq_wr,
	output rtfb_pkg::frame_t     fq_wdata
);

	logic [7:0] options_q;
	logic [7:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			options_q <= rtfb_pkg::OPT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			options_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign full      = fq_full;
	assign fq_wr     = push && !fq_full;

	// The sum wraps at eight bits, which is all the checksum needs.
	assign sum = rtfb_pkg::FRAME_TYPE + rtfb_pkg::FRAME_ID + req.dest_addr_high
		+ req.dest_addr_low + options_q + req.data_first + req.data_second;

	always_comb begin
		fq_wdata.addr_high   = req.dest_addr_high;
		fq_wdata.addr_low    = req.dest_addr_low;
		fq_wdata.options     = options_q;
		fq_wdata.data_first  = req.data_first;
		fq_wdata.data_second = req.data_second;
		fq_wdata.checksum    = rtfb_pkg::CKS_BASE - sum;
	end

`ifndef ASSERT_OFF
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> options_q == $past(cfg_data))
		else $error("options register did not take the written word");
	a_frame_sum: assert property (@(posedge clk) disable iff (!arst_n)
		fq_wr |-> 8'(sum + fq_wdata.checksum) == rtfb_pkg::CKS_BASE)
		else $error("checksum does not complete the frame sum");
`endif

endmodule
`default_nettype wire

FILE: design/rtfb_fqueue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtfb_fqueue: frame queue
// Short queue of frame records between the intake and the serializer.
// ----------------------------------------------------------------------------
module rtfb_fqueue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire rtfb_pkg::frame_t  wdata,
	output logic                   full,
	input  wire logic              rd,
	output logic                   valid,
	output rtfb_pkg::frame_t       rdata
);

	rtfb_pkg::frame_t                mem_q [rtfb_pkg::FQ_DEPTH];
	logic [rtfb_pkg::FQ_PTR_W-1:0]   wr_ptr_q;
	logic [rtfb_pkg::FQ_PTR_W-1:0]   rd_ptr_q;
	logic [rtfb_pkg::FQ_CNT_W-1:0]   cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full  = cnt_q == rtfb_pkg::FQ_CNT_W'(rtfb_pkg::FQ_DEPTH);
	assign valid = cnt_q != '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == rtfb_pkg::FQ_PTR_W'(rtfb_pkg::FQ_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == rtfb_pkg::FQ_PTR_W'(rtfb_pkg::FQ_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_fq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rtfb_pkg::FQ_CNT_W'(rtfb_pkg::FQ_DEPTH))
		else $error("frame queue count beyond depth");
	a_fq_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> valid)
		else $error("frame queue read while empty");
`endif

endmodule
`default_nettype wire

FILE: design/rtfb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtfb_back: frame serializer
// Walks the frame byte by byte, inserts escape bytes and places each word
// in a two-entry output buffer for the receiver; holds while it is full or no frame is queued.
// ----------------------------------------------------------------------------
module rtfb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fq_valid,
	input  wire rtfb_pkg::frame_t  fq_rdata,
	output logic                   fq_rd,
	output logic                   empty,
	input  wire logic              pop,
	output rtfb_pkg::rsp_t         rsp
);

	rtfb_pkg::pos_t                  pos_q;
	rtfb_pkg::pos_t                  pos_d;
	logic                            esc_q;
	logic                            esc_d;
	rtfb_pkg::rsp_t                  ob_q [rtfb_pkg::OB_DEPTH];
	logic [rtfb_pkg::OB_PTR_W-1:0]   ob_wr_ptr_q;
	logic [rtfb_pkg::OB_PTR_W-1:0]   ob_rd_ptr_q;
	logic [rtfb_pkg::OB_CNT_W-1:0]   ob_cnt_q;
	logic [7:0]                      raw;
	logic                            emit;
	logic                            advance;
	logic                            ob_rd;
	rtfb_pkg::rsp_t                  word;

	always_comb begin
		case (pos_q)
			rtfb_pkg::POS_DELIM:       raw = rtfb_pkg::START_DELIM;
			rtfb_pkg::POS_LEN_HIGH:    raw = rtfb_pkg::LEN_HIGH;
			rtfb_pkg::POS_LEN_LOW:     raw = rtfb_pkg::LEN_LOW;
			rtfb_pkg::POS_TYPE:        raw = rtfb_pkg::FRAME_TYPE;
			rtfb_pkg::POS_ID:          raw = rtfb_pkg::FRAME_ID;
			rtfb_pkg::POS_ADDR_HIGH:   raw = fq_rdata.addr_high;
			rtfb_pkg::POS_ADDR_LOW:    raw = fq_rdata.addr_low;
			rtfb_pkg::POS_OPTIONS:     raw = fq_rdata.options;
			rtfb_pkg::POS_DATA_FIRST:  raw = fq_rdata.data_first;
			rtfb_pkg::POS_DATA_SECOND: raw = fq_rdata.data_second;
			rtfb_pkg::POS_CHECKSUM:    raw = fq_rdata.checksum;
			default:                   raw = rtfb_pkg::START_DELIM;
		endcase
	end

	assign emit  = fq_valid && (ob_cnt_q != rtfb_pkg::OB_CNT_W'(rtfb_pkg::OB_DEPTH));
	assign ob_rd = pop && !empty;
	assign empty = ob_cnt_q == '0;
	assign rsp   = ob_q[ob_rd_ptr_q];

	// An escaped byte takes two words: the escape byte, then the byte with
	// bit 5 flipped. The position only moves on after the second word.
	always_comb begin
		pos_d          = pos_q;
		esc_d          = esc_q;
		advance        = 1'b0;
		word.out_byte  = raw;
		word.last_byte = 1'b0;
		fq_rd          = 1'b0;
		if (emit) begin
			if (esc_q) begin
				word.out_byte = raw ^ rtfb_pkg::ESC_XOR;
				esc_d         = 1'b0;
				advance       = 1'b1;
			end else if (pos_q != rtfb_pkg::POS_DELIM && rtfb_pkg::needs_escape(raw)) begin
				word.out_byte = rtfb_pkg::ESC_BYTE;
				esc_d         = 1'b1;
			end else begin
				advance = 1'b1;
			end
			if (advance) begin
				if (pos_q == rtfb_pkg::POS_CHECKSUM) begin
					pos_d          = rtfb_pkg::POS_DELIM;
					word.last_byte = 1'b1;
					fq_rd          = 1'b1;
				end else begin
					pos_d = rtfb_pkg::pos_t'(pos_q + 4'd1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= rtfb_pkg::POS_DELIM;
			esc_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			esc_q <= esc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q[ob_wr_ptr_q] <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_ptr_q <= '0;
			ob_rd_ptr_q <= '0;
			ob_cnt_q    <= '0;
		end else begin
			if (emit) begin
				ob_wr_ptr_q <= (ob_wr_ptr_q == rtfb_pkg::OB_PTR_W'(rtfb_pkg::OB_DEPTH - 1))
					? '0 : ob_wr_ptr_q + 1'b1;
			end
			if (ob_rd) begin
				ob_rd_ptr_q <= (ob_rd_ptr_q == rtfb_pkg::OB_PTR_W'(rtfb_pkg::OB_DEPTH - 1))
					? '0 : ob_rd_ptr_q + 1'b1;
			end
			if (emit && !ob_rd) begin
				ob_cnt_q <= ob_cnt_q + 1'b1;
			end else if (ob_rd && !emit) begin
				ob_cnt_q <= ob_cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_esc_pos: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> pos_q != rtfb_pkg::POS_DELIM)
		else $error("escape pending on the start delimiter");
	a_esc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q && !emit |=> esc_q && $stable(pos_q))
		else $error("escape state lost while stalled");
	a_ob_count: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q <= rtfb_pkg::OB_CNT_W'(rtfb_pkg::OB_DEPTH))
		else $error("output buffer count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: design/radio_api_tx_frame_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radio_api_tx_frame_builder: escaped transmit-request frame builder
// Turns each request into one escaped radio transmit frame, one byte a word.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on push/full and are taken at an edge with push high and
//   full low. Each one carries a 16-bit destination and two data bytes.
//   The options byte comes from the configuration channel (cfg_valid,
//   cfg_ready, cfg_data), which is always ready; reset loads 0x01.
//   Frame bytes leave on empty/pop: the oldest word is on rsp while empty is
//   low, and it is taken at an edge with pop high and empty low. The final
//   word of a frame has last_byte set.
//   A frame is 11 to 17 words. The serializer sends one word per cycle while
//   the output buffer has room; a request is registered in the frame queue and
//   its first word in the output buffer before it shows on rsp.
//   The frame queue holds the frame being sent and one more, so a new request
//   is taken while a frame is being sent. If the receiver stops popping, the
//   two-word output buffer fills, the serializer holds, and full rises once
//   the queue fills.
//   Reset empties both queues and restarts the serializer.
// ----------------------------------------------------------------------------
module radio_api_tx_frame_builder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire rtfb_pkg::req_t  req,
	output logic                 empty,
	input  wire logic            pop,
	output rtfb_pkg::rsp_t       rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [7:0]      cfg_data
);

	logic              fq_wr;
	logic              fq_full;
	logic              fq_rd;
	logic              fq_valid;
	rtfb_pkg::frame_t  fq_wdata;
	rtfb_pkg::frame_t  fq_rdata;

	rtfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fq_full   (fq_full),
		.fq_wr     (fq_wr),
		.fq_wdata  (fq_wdata)
	);

	rtfb_fqueue u_fqueue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_wr),
		.wdata  (fq_wdata),
		.full   (fq_full),
		.rd     (fq_rd),
		.valid  (fq_valid),
		.rdata  (fq_rdata)
	);

	rtfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_valid (fq_valid),
		.fq_rdata (fq_rdata),
		.fq_rd    (fq_rd),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
